FILE: rtl/core/raster_minima_fill_defines.svh
// Assertion macros shared by the raster fill RTL.
`ifndef RASTER_MINIMA_FILL_DEFINES_SVH
`define RASTER_MINIMA_FILL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RMF_CHECK_IMPL(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("raster fill check failed");

// Next-cycle implication, disabled during reset.
`define RMF_CHECK_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("raster fill check failed");

`endif

FILE: rtl/core/rmf_pkg.sv
// Types, constants and helpers for the raster minima fill block.
`timescale 1ns / 1ps

package rmf_pkg;

  localparam int ROW_BITS  = 8;
  localparam int COL_BITS  = 8;
  localparam int PIX_BITS  = ROW_BITS + COL_BITS;
  localparam int VAL_BITS  = 16;
  localparam int CNT_BITS  = 9;
  localparam int BIT_SEL   = 5;
  localparam int WORD_BITS = 1 << BIT_SEL;
  localparam int FLAG_ADDR = PIX_BITS - BIT_SEL;
  localparam int CIDX_BITS = 3;

  localparam logic [CNT_BITS-1:0] ROWS_MAX = CNT_BITS'(1 << ROW_BITS);
  localparam logic [CNT_BITS-1:0] COLS_MAX = CNT_BITS'(1 << COL_BITS);

  // Request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_BITS-1:0] CFG_LEVEL_MIN = 3'd0;
  localparam logic [CIDX_BITS-1:0] CFG_LEVEL_MAX = 3'd1;
  localparam logic [CIDX_BITS-1:0] CFG_BOUNDARY  = 3'd2;
  localparam logic [CIDX_BITS-1:0] CFG_ROW_COUNT = 3'd3;
  localparam logic [CIDX_BITS-1:0] CFG_COL_COUNT = 3'd4;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic [ROW_BITS-1:0]        row;
    logic [COL_BITS-1:0]        col;
    logic signed [VAL_BITS-1:0] elevation;
    logic                       is_null;
    logic                       is_boundary;
  } req_t;

  typedef struct packed {
    logic signed [VAL_BITS-1:0] filled_value;
    logic                       status;
  } rsp_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic ld_item;
    logic wr_pix;
    logic enq_rd;
    logic enq_wr;
    logic rd_pix;
    logic out_load;
    logic out_read;
    logic out_err;
    logic lv_init;
    logic lv_inc;
    logic rd_lvl;
    logic deq;
    logic deq_fin;
    logic nb_rd;
    logic nb_upd;
    logic nb_next;
    logic clr_step;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] in_req;
    logic       item_bnd;
    logic       seed_bad;
    logic       empty_range;
    logic       lvl_nonempty;
    logic       lv_last;
    logic       nb_in;
    logic       nb_skip;
    logic       v_over;
    logic       n_last;
    logic       clr_last;
  } stat_t;

  typedef struct packed {
    logic signed [1:0] dr;
    logic signed [1:0] dc;
  } nb_off_t;

  // Neighbor offsets in raster scan order around the center pixel
  function automatic nb_off_t nb_offset(input logic [2:0] n);
    nb_off_t o;
    unique case (n)
      3'd0:    o = '{dr: -2'sd1, dc: -2'sd1};
      3'd1:    o = '{dr: -2'sd1, dc:  2'sd0};
      3'd2:    o = '{dr: -2'sd1, dc:  2'sd1};
      3'd3:    o = '{dr:  2'sd0, dc: -2'sd1};
      3'd4:    o = '{dr:  2'sd0, dc:  2'sd1};
      3'd5:    o = '{dr:  2'sd1, dc: -2'sd1};
      3'd6:    o = '{dr:  2'sd1, dc:  2'sd0};
      default: o = '{dr:  2'sd1, dc:  2'sd1};
    endcase
    return o;
  endfunction

endpackage

FILE: rtl/core/raster_minima_fill.sv
// Raster minima fill: priority-flood depression filling on a hierarchical queue.
// Pixel write: S_WRITE, then S_ENQ_RD and S_ENQ_WR for a boundary pixel (queue insert).
// Read: S_READ_RD, S_READ_OUT. Run: S_LVL_RD, S_LVL_CHK per level scanned, S_DEQ_FIN per
//   dequeued pixel; per neighbor S_NB_ADDR, plus S_NB_CHK if in bounds and S_ENQ_RD,
//   S_ENQ_WR if flooded and queued; then the waiting and level flag sweep and S_RESULT.
// One item at a time; the flood walk and the flag sweep set the run time.
// Reset (synchronous, active high) runs the same sweep; no item is taken.
`timescale 1ns / 1ps
`include "raster_minima_fill_defines.svh"

module raster_minima_fill (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rmf_pkg::CIDX_BITS-1:0] cfg_index,
  input  logic [rmf_pkg::VAL_BITS-1:0]  cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  rmf_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output rmf_pkg::rsp_t                 rsp
);
  import rmf_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  rsp_busy;

  assign rsp_busy = rsp_valid && rsp_stall;

  rmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_busy  (rsp_busy),
    .stat      (stat),
    .cmd       (cmd)
  );

  rmf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  // A new result never lands on one still waiting
  `RMF_CHECK_IMPL(a_no_overwrite, clk, rst, cmd.out_load, !rsp_busy)
  // No transfer is taken during the flag sweep
  `RMF_CHECK_IMPL(a_no_take_in_sweep, clk, rst, req_valid && !req_stall, !cmd.clr_step)
  // A dequeue always finishes in the next cycle
  `RMF_CHECK_NEXT(a_deq_finish, clk, rst, cmd.deq, cmd.deq_fin)

endmodule

FILE: rtl/core/rmf_ctrl.sv
// Controller state machine sequencing load, read, flood and queue clear.
`timescale 1ns / 1ps

module rmf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  logic          rsp_busy,
  input  rmf_pkg::stat_t stat,
  output rmf_pkg::cmd_t  cmd
);
  import rmf_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_WRITE    = 14'b00000000000010,
    S_ENQ_RD   = 14'b00000000000100,
    S_ENQ_WR   = 14'b00000000001000,
    S_READ_RD  = 14'b00000000010000,
    S_READ_OUT = 14'b00000000100000,
    S_RUN_CHK  = 14'b00000001000000,
    S_LVL_RD   = 14'b00000010000000,
    S_LVL_CHK  = 14'b00000100000000,
    S_DEQ_FIN  = 14'b00001000000000,
    S_NB_ADDR  = 14'b00010000000000,
    S_NB_CHK   = 14'b00100000000000,
    S_CLEAR    = 14'b01000000000000,
    S_RESULT   = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic   run, run_next;
  logic   err, err_next;
  logic   accept;

  // Take an item only when idle and the result slot is free
  assign req_stall = (state != S_IDLE) || rsp_busy;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      run   <= 1'b0;
      err   <= 1'b0;
    end else begin
      state <= state_next;
      run   <= run_next;
      err   <= err_next;
    end
  end

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    run_next   = run;
    err_next   = err;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.ld_item = 1'b1;
          case (stat.in_req)
            REQ_WRITE: state_next = S_WRITE;
            REQ_RUN: begin
              state_next = S_RUN_CHK;
              run_next   = 1'b1;
            end
            REQ_READ: state_next = S_READ_RD;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        cmd.wr_pix = 1'b1;
        state_next = stat.item_bnd ? S_ENQ_RD : S_IDLE;
      end
      S_ENQ_RD: begin
        cmd.enq_rd = 1'b1;
        state_next = S_ENQ_WR;
      end
      S_ENQ_WR: begin
        cmd.enq_wr = 1'b1;
        if (!run) begin
          state_next = S_IDLE;
        end else if (stat.n_last) begin
          state_next = S_LVL_RD;
        end else begin
          cmd.nb_next = 1'b1;
          state_next  = S_NB_ADDR;
        end
      end
      S_READ_RD: begin
        cmd.rd_pix = 1'b1;
        state_next = S_READ_OUT;
      end
      S_READ_OUT: begin
        cmd.out_load = 1'b1;
        cmd.out_read = 1'b1;
        state_next   = S_IDLE;
      end
      S_RUN_CHK: begin
        if (stat.seed_bad) begin
          err_next   = 1'b1;
          state_next = S_CLEAR;
        end else if (stat.empty_range) begin
          err_next   = 1'b0;
          state_next = S_CLEAR;
        end else begin
          err_next    = 1'b0;
          cmd.lv_init = 1'b1;
          state_next  = S_LVL_RD;
        end
      end
      S_LVL_RD: begin
        cmd.rd_lvl = 1'b1;
        state_next = S_LVL_CHK;
      end
      S_LVL_CHK: begin
        if (stat.lvl_nonempty) begin
          cmd.deq    = 1'b1;
          state_next = S_DEQ_FIN;
        end else if (stat.lv_last) begin
          state_next = S_CLEAR;
        end else begin
          cmd.lv_inc = 1'b1;
          state_next = S_LVL_RD;
        end
      end
      S_DEQ_FIN: begin
        cmd.deq_fin = 1'b1;
        state_next  = S_NB_ADDR;
      end
      S_NB_ADDR: begin
        if (stat.nb_in) begin
          cmd.nb_rd  = 1'b1;
          state_next = S_NB_CHK;
        end else if (stat.n_last) begin
          state_next = S_LVL_RD;
        end else begin
          cmd.nb_next = 1'b1;
          state_next  = S_NB_ADDR;
        end
      end
      S_NB_CHK: begin
        if (stat.nb_skip) begin
          if (stat.n_last) begin
            state_next = S_LVL_RD;
          end else begin
            cmd.nb_next = 1'b1;
            state_next  = S_NB_ADDR;
          end
        end else begin
          cmd.nb_upd = 1'b1;
          if (stat.v_over) begin
            err_next   = 1'b1;
            state_next = S_CLEAR;
          end else begin
            state_next = S_ENQ_RD;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = run ? S_RESULT : S_IDLE;
        end
      end
      S_RESULT: begin
        cmd.out_load = 1'b1;
        cmd.out_err  = err;
        run_next     = 1'b0;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/rmf_dp.sv
// Datapath: configuration, pixel and queue memories, flood arithmetic, result register.
`timescale 1ns / 1ps

module rmf_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rmf_pkg::CIDX_BITS-1:0]     cfg_index,
  input  logic [rmf_pkg::VAL_BITS-1:0]      cfg_data,
  input  rmf_pkg::req_t                     req,
  input  rmf_pkg::cmd_t                     cmd,
  output rmf_pkg::stat_t                    stat,
  input  logic                              rsp_stall,
  output logic                              rsp_valid,
  output rmf_pkg::rsp_t                     rsp
);
  import rmf_pkg::*;

  // Configuration
  logic signed [VAL_BITS-1:0] level_min, level_max, boundary_level;
  logic [CNT_BITS-1:0]        row_count, col_count;

  // Working registers
  req_t                       item;
  logic signed [VAL_BITS-1:0] lv, lv_nxt;
  logic [PIX_BITS-1:0]        p_cur, q_cur, enq_pix;
  logic [VAL_BITS-1:0]        enq_lvl;
  logic [2:0]                 n;
  logic                       deq_eq;
  logic                       seed_any;
  logic signed [VAL_BITS-1:0] seed_min, seed_max;
  logic [FLAG_ADDR-1:0]       clr_addr;

  // Memories and their registered read data
  logic [VAL_BITS:0]       pix_mem  [1<<PIX_BITS];
  logic [VAL_BITS-1:0]     fill_mem [1<<PIX_BITS];
  logic [PIX_BITS-1:0]     link_mem [1<<PIX_BITS];
  logic [PIX_BITS-1:0]     head_mem [1<<VAL_BITS];
  logic [PIX_BITS-1:0]     tail_mem [1<<VAL_BITS];
  logic [WORD_BITS-1:0]    wait_mem [1<<FLAG_ADDR];
  logic [WORD_BITS-1:0]    ne_mem   [1<<FLAG_ADDR];
  logic [VAL_BITS:0]       pix_q;
  logic [VAL_BITS-1:0]     fill_q;
  logic [PIX_BITS-1:0]     link_q, head_q, tail_q;
  logic [WORD_BITS-1:0]    wait_q, ne_q;

  logic [PIX_BITS-1:0]  item_pix, lv_addr, q_addr;
  logic [CNT_BITS-1:0]  rows_eff, cols_eff;
  nb_off_t              off;
  logic signed [9:0]    nr, nc;
  logic                 pix_null;
  logic signed [VAL_BITS-1:0] pix_elev, v;
  logic                 wait_bit, ne_bit, enq_new;

  assign item_pix = {item.row, item.col};
  assign lv_addr  = lv;
  assign lv_nxt   = lv + 16'sd1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      level_min      <= 16'sd0;
      level_max      <= 16'sd32767;
      boundary_level <= 16'sd0;
      row_count      <= ROWS_MAX;
      col_count      <= COLS_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEVEL_MIN: level_min      <= cfg_data;
        CFG_LEVEL_MAX: level_max      <= cfg_data;
        CFG_BOUNDARY:  boundary_level <= cfg_data;
        CFG_ROW_COUNT: row_count      <= cfg_data[CNT_BITS-1:0];
        CFG_COL_COUNT: col_count      <= cfg_data[CNT_BITS-1:0];
        default:       ;
      endcase
    end
  end

  // Neighbor address and bounds
  assign rows_eff = (row_count > ROWS_MAX) ? ROWS_MAX : row_count;
  assign cols_eff = (col_count > COLS_MAX) ? COLS_MAX : col_count;
  assign off      = nb_offset(n);
  assign nr = $signed({2'b00, p_cur[PIX_BITS-1:COL_BITS]}) + {{8{off.dr[1]}}, off.dr};
  assign nc = $signed({2'b00, p_cur[COL_BITS-1:0]}) + {{8{off.dc[1]}}, off.dc};
  assign q_addr = {nr[ROW_BITS-1:0], nc[COL_BITS-1:0]};

  // Flood value of the visited neighbor
  assign pix_null = pix_q[VAL_BITS];
  assign pix_elev = pix_q[VAL_BITS-1:0];
  assign v        = (pix_elev > lv) ? pix_elev : lv;

  // Queue flag bits
  assign wait_bit = wait_q[enq_pix[BIT_SEL-1:0]];
  assign ne_bit   = ne_q[enq_lvl[BIT_SEL-1:0]];
  assign enq_new  = cmd.enq_wr && !wait_bit;

  // Status
  always_comb begin
    stat.in_req       = req.req_type;
    stat.item_bnd     = item.is_boundary;
    stat.seed_bad     = seed_any && ((seed_min < level_min) || (seed_max > level_max));
    stat.empty_range  = !(level_min < level_max);
    stat.lvl_nonempty = ne_q[lv_addr[BIT_SEL-1:0]];
    stat.lv_last      = !(lv_nxt < level_max);
    stat.nb_in        = !nr[9] && (nr[CNT_BITS-1:0] < rows_eff) &&
                        !nc[9] && (nc[CNT_BITS-1:0] < cols_eff);
    stat.nb_skip      = pix_null || ($signed(fill_q) != level_max);
    stat.v_over       = v > level_max;
    stat.n_last       = (n == 3'd7);
    stat.clr_last     = &clr_addr;
  end

  // Item, level, pixel and neighbor registers
  always_ff @(posedge clk) begin
    if (cmd.ld_item) item <= req;
    if (cmd.lv_init) lv <= level_min;
    else if (cmd.lv_inc) lv <= lv_nxt;
    if (cmd.deq) begin
      p_cur  <= head_q;
      deq_eq <= (head_q == tail_q);
      n      <= 3'd0;
    end else if (cmd.nb_next) begin
      n <= n + 3'd1;
    end
    if (cmd.nb_rd) q_cur <= q_addr;
    if (cmd.wr_pix) begin
      enq_pix <= item_pix;
      enq_lvl <= boundary_level;
    end else if (cmd.nb_upd) begin
      enq_pix <= q_cur;
      enq_lvl <= v;
    end
  end

  // Seed level range and clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_any <= 1'b0;
      clr_addr <= '0;
    end else begin
      if (cmd.clr_step) begin
        seed_any <= 1'b0;
        clr_addr <= clr_addr + 1'b1;
      end else if (enq_new) begin
        seed_any <= 1'b1;
        if (!seed_any || ($signed(enq_lvl) < seed_min)) seed_min <= enq_lvl;
        if (!seed_any || ($signed(enq_lvl) > seed_max)) seed_max <= enq_lvl;
      end
    end
  end

  // Elevation and null store
  always_ff @(posedge clk) begin
    if (cmd.wr_pix) pix_mem[item_pix] <= {item.is_null, item.elevation};
    if (cmd.nb_rd) pix_q <= pix_mem[q_addr];
  end

  // Filled store
  always_ff @(posedge clk) begin
    if (cmd.wr_pix) begin
      fill_mem[item_pix] <= item.is_boundary ? boundary_level : level_max;
    end else if (cmd.nb_upd) begin
      fill_mem[q_cur] <= v;
    end
    if (cmd.rd_pix) fill_q <= fill_mem[item_pix];
    else if (cmd.nb_rd) fill_q <= fill_mem[q_addr];
  end

  // Queue links
  always_ff @(posedge clk) begin
    if (enq_new && ne_bit) link_mem[tail_q] <= enq_pix;
    if (cmd.deq) link_q <= link_mem[head_q];
  end

  // Level heads
  always_ff @(posedge clk) begin
    if (enq_new && !ne_bit) head_mem[enq_lvl] <= enq_pix;
    else if (cmd.deq_fin && !deq_eq) head_mem[lv_addr] <= link_q;
    if (cmd.rd_lvl) head_q <= head_mem[lv_addr];
  end

  // Level tails
  always_ff @(posedge clk) begin
    if (enq_new) tail_mem[enq_lvl] <= enq_pix;
    if (cmd.rd_lvl) tail_q <= tail_mem[lv_addr];
    else if (cmd.enq_rd) tail_q <= tail_mem[enq_lvl];
  end

  // Waiting flags, 32 pixels a word
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      wait_mem[clr_addr] <= '0;
    end else if (enq_new) begin
      wait_mem[enq_pix[PIX_BITS-1:BIT_SEL]] <=
        wait_q | (WORD_BITS'(1) << enq_pix[BIT_SEL-1:0]);
    end else if (cmd.deq_fin) begin
      wait_mem[p_cur[PIX_BITS-1:BIT_SEL]] <=
        wait_q & ~(WORD_BITS'(1) << p_cur[BIT_SEL-1:0]);
    end
    if (cmd.enq_rd) wait_q <= wait_mem[enq_pix[PIX_BITS-1:BIT_SEL]];
    else if (cmd.deq) wait_q <= wait_mem[head_q[PIX_BITS-1:BIT_SEL]];
  end

  // Level nonempty flags, 32 levels a word
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      ne_mem[clr_addr] <= '0;
    end else if (enq_new && !ne_bit) begin
      ne_mem[enq_lvl[VAL_BITS-1:BIT_SEL]] <=
        ne_q | (WORD_BITS'(1) << enq_lvl[BIT_SEL-1:0]);
    end else if (cmd.deq && (head_q == tail_q)) begin
      ne_mem[lv_addr[VAL_BITS-1:BIT_SEL]] <=
        ne_q & ~(WORD_BITS'(1) << lv_addr[BIT_SEL-1:0]);
    end
    if (cmd.rd_lvl) ne_q <= ne_mem[lv_addr[VAL_BITS-1:BIT_SEL]];
    else if (cmd.enq_rd) ne_q <= ne_mem[enq_lvl[VAL_BITS-1:BIT_SEL]];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.filled_value <= cmd.out_read ? $signed(fill_q) : 16'sd0;
      rsp.status       <= cmd.out_err;
    end
  end

endmodule
